@@ rtl/seglcd_pkg.sv @@
// Shared types, codes and character tables for the segment LCD text writer.
package seglcd_pkg;

  // Command codes carried in the action field.
  localparam logic [1:0] ACT_CHAR   = 2'd0;
  localparam logic [1:0] ACT_NUMBER = 2'd1;
  localparam logic [1:0] ACT_DIGITS = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // Source of the character that the write unit places.
  localparam logic [1:0] WR_CHAR = 2'd0;
  localparam logic [1:0] WR_NUM  = 2'd1;
  localparam logic [1:0] WR_HI   = 2'd2;
  localparam logic [1:0] WR_LO   = 2'd3;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          QUOT_W      = 64 - RECIP_SHIFT;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         char_code;
    logic [3:0]         position;
    logic signed [31:0] number;
  } seglcd_req_t;

  typedef struct packed {
    logic        status;
    logic [23:0] row0_bits;
    logic [23:0] row1_bits;
    logic [23:0] row2_bits;
    logic [23:0] row3_bits;
  } seglcd_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       clear;
    logic       mul;
    logic       div_step;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       finish;
  } seglcd_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       x_zero;
    logic       q_zero;
    logic       k_first;
    logic       k_last;
    logic       wr_err;
    logic       out_free;
  } seglcd_sts_t;

  // Segment code of a lowercase letter, indexed from 'a'.
  function automatic logic [15:0] letter_code(input logic [4:0] idx);
    logic [15:0] code;
    case (idx)
      5'd0:    code = 16'h0f51;
      5'd1:    code = 16'h3991;
      5'd2:    code = 16'h1441;
      5'd3:    code = 16'h3191;
      5'd4:    code = 16'h1641;
      5'd5:    code = 16'h0641;
      5'd6:    code = 16'h1d41;
      5'd7:    code = 16'h0f50;
      5'd8:    code = 16'h3081;
      5'd9:    code = 16'h1510;
      5'd10:   code = 16'h8648;
      5'd11:   code = 16'h1440;
      5'd12:   code = 16'h0578;
      5'd13:   code = 16'h8570;
      5'd14:   code = 16'h1551;
      5'd15:   code = 16'h0e51;
      5'd16:   code = 16'h9551;
      5'd17:   code = 16'h8e51;
      5'd18:   code = 16'h9241;
      5'd19:   code = 16'h2081;
      5'd20:   code = 16'h1550;
      5'd21:   code = 16'h4448;
      5'd22:   code = 16'hc550;
      5'd23:   code = 16'hc028;
      5'd24:   code = 16'h1b50;
      5'd25:   code = 16'h5009;
      default: code = 16'h0000;
    endcase
    return code;
  endfunction

  // Segment code of a decimal digit.
  function automatic logic [15:0] digit_code(input logic [3:0] idx);
    logic [15:0] code;
    case (idx)
      4'd0:    code = 16'h5559;
      4'd1:    code = 16'h0118;
      4'd2:    code = 16'h1e11;
      4'd3:    code = 16'h1911;
      4'd4:    code = 16'h0b50;
      4'd5:    code = 16'h1b41;
      4'd6:    code = 16'h1f41;
      4'd7:    code = 16'h0111;
      4'd8:    code = 16'h1f51;
      4'd9:    code = 16'h1b51;
      default: code = 16'h0000;
    endcase
    return code;
  endfunction

  // Returns {valid, code}; uppercase folds to lowercase.
  function automatic logic [16:0] char_lookup(input logic [7:0] ch);
    logic [7:0]  lc;
    logic [16:0] res;
    lc = ch;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      lc = ch + CASE_OFFSET;
    end
    if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z) begin
      res = {1'b1, letter_code(5'(lc - CHAR_LOWER_A))};
    end else if (lc >= CHAR_ZERO && lc <= CHAR_NINE) begin
      res = {1'b1, digit_code(4'(lc - CHAR_ZERO))};
    end else begin
      res = 17'd0;
    end
    return res;
  endfunction

endpackage

@@ rtl/seglcd_datapath.sv @@
// Datapath: request fields, decimal digit extraction, segment rows and result register.
module seglcd_datapath #(
  parameter int NUM_POSITIONS = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  seglcd_pkg::seglcd_req_t  req,
  input  seglcd_pkg::seglcd_cmd_t  cmd,
  input  logic [7:0]               protected_bits_mask,
  input  logic                     rsp_stall,
  output seglcd_pkg::seglcd_sts_t  sts,
  output logic                     rsp_valid,
  output seglcd_pkg::seglcd_rsp_t  rsp
);
  import seglcd_pkg::*;

  localparam int         KW        = $clog2(NUM_POSITIONS);
  localparam logic [4:0] POS_LIMIT = 5'(NUM_POSITIONS);
  localparam logic [4:0] POS_LAST  = 5'(NUM_POSITIONS - 1);
  localparam logic [KW-1:0] K_LAST = KW'(NUM_POSITIONS - 1);

  logic [1:0]        action;
  logic [7:0]        char_code;
  logic [3:0]        position;
  logic              neg;
  logic [31:0]       x;
  logic [QUOT_W-1:0] q;
  logic [KW-1:0]     k;
  logic [3:0]        d0;
  logic [3:0]        d1;
  logic              d0_neg;
  logic              d1_neg;
  logic              status;
  logic [23:0]       rows [4];

  logic [3:0]  rem;
  logic        rem_neg;
  logic [63:0] product;
  logic [7:0]  wr_ch;
  logic [4:0]  wr_pos;
  logic        wr_bad;
  logic [16:0] lookup;
  logic        wr_err;
  logic        wr_do;
  logic [4:0]  shift;
  logic [23:0] lane;
  logic [23:0] row_mask [4];
  logic [23:0] row_data [4];

  // Remainder of x by ten from the registered quotient; four bits are exact.
  assign rem     = x[3:0] - {q[0], 3'b000} - {q[2:0], 1'b0};
  assign rem_neg = neg && (rem != 4'd0);
  assign product = 64'(x) * 64'(RECIP_TEN);

  // Pick the character and position for this write.
  always_comb begin
    case (cmd.wr_sel)
      WR_CHAR: begin
        wr_ch  = char_code;
        wr_pos = {1'b0, position};
        wr_bad = 1'b0;
      end
      WR_NUM: begin
        wr_ch  = CHAR_ZERO + 8'(rem);
        wr_pos = POS_LAST - 5'(k);
        wr_bad = rem_neg;
      end
      WR_HI: begin
        wr_ch  = CHAR_ZERO + 8'(d1);
        wr_pos = {1'b0, position};
        wr_bad = d1_neg;
      end
      WR_LO: begin
        wr_ch  = CHAR_ZERO + 8'(d0);
        wr_pos = {1'b0, position} + 5'd1;
        wr_bad = d0_neg;
      end
      default: begin
        wr_ch  = char_code;
        wr_pos = {1'b0, position};
        wr_bad = 1'b0;
      end
    endcase
  end

  assign lookup = char_lookup(wr_ch);
  assign wr_err = wr_bad || (wr_pos >= POS_LIMIT) || !lookup[16];
  assign wr_do  = cmd.wr_en && !wr_err;

  // Each code nibble lands in its row at the nibble slot of the position.
  assign shift = {wr_pos[2:0], 2'b00};
  assign lane  = 24'h00000F << shift;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_data[r] = 24'(lookup[4*r +: 4]) << shift;
      row_mask[r] = lane;
    end
    row_mask[0] = lane & ~{3{protected_bits_mask}};
  end

  // Status back to the controller.
  always_comb begin
    sts.action   = action;
    sts.x_zero   = (x == 32'd0);
    sts.q_zero   = (q == '0);
    sts.k_first  = (k == '0);
    sts.k_last   = (k == K_LAST);
    sts.wr_err   = wr_err;
    sts.out_free = !rsp_valid || !rsp_stall;
  end

  // Request capture and digit extraction registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action    <= req.action;
      char_code <= req.char_code;
      position  <= req.position;
      neg       <= req.number[31];
      x         <= req.number[31] ? 32'(-req.number) : 32'(req.number);
    end
    if (cmd.mul) begin
      q <= product[63:RECIP_SHIFT];
    end
    if (cmd.div_step) begin
      x <= 32'(q);
      if (k == '0) begin
        d0     <= rem;
        d0_neg <= rem_neg;
      end else begin
        d1     <= rem;
        d1_neg <= rem_neg;
      end
    end
  end

  // Digit counter and command status.
  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      status <= 1'b0;
    end else begin
      if (cmd.load) begin
        k      <= '0;
        status <= 1'b0;
      end else begin
        if (cmd.div_step) begin
          k <= k + KW'(1);
        end
        if (cmd.wr_en && wr_err) begin
          status <= 1'b1;
        end
      end
    end
  end

  // Segment rows: masked nibble writes and the clear command.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        rows[r] <= 24'd0;
      end
    end else if (cmd.clear) begin
      rows[0] <= rows[0] & {3{protected_bits_mask}};
      for (int r = 1; r < 4; r++) begin
        rows[r] <= 24'd0;
      end
    end else if (wr_do) begin
      for (int r = 0; r < 4; r++) begin
        rows[r] <= (rows[r] & ~row_mask[r]) | (row_data[r] & row_mask[r]);
      end
    end
  end

  // Result register holds until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status    <= status;
      rsp.row0_bits <= rows[0];
      rsp.row1_bits <= rows[1];
      rsp.row2_bits <= rows[2];
      rsp.row3_bits <= rows[3];
    end
  end

endmodule

@@ rtl/seglcd_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
module seglcd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  seglcd_pkg::seglcd_sts_t sts,
  output seglcd_pkg::seglcd_cmd_t cmd
);
  import seglcd_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_DIG      = 3'd3;
  localparam logic [2:0] S_PUT_HI   = 3'd4;
  localparam logic [2:0] S_PUT_LO   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_sel = WR_CHAR;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.action)
          ACT_CHAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_CHAR;
            state_next = S_DONE;
          end
          ACT_NUMBER: begin
            state_next = sts.x_zero ? S_DONE : S_MUL;
          end
          ACT_DIGITS: begin
            state_next = S_MUL;
          end
          ACT_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIG;
      end
      S_DIG: begin
        cmd.div_step = 1'b1;
        if (sts.action == ACT_NUMBER) begin
          // Write this digit right-aligned, then stop on error or when done.
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_NUM;
          if (sts.wr_err || sts.q_zero || sts.k_last) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MUL;
          end
        end else begin
          // Two-digit write: extract units first, then tens.
          state_next = sts.k_first ? S_MUL : S_PUT_HI;
        end
      end
      S_PUT_HI: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_HI;
        state_next = sts.wr_err ? S_DONE : S_PUT_LO;
      end
      S_PUT_LO: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_LO;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/segment_lcd_text_writer_unit.sv @@
// Top level of the six-position 14-segment LCD text writer.
//
// A request on req (valid/stall) carries an action, a character, a position
// and a signed number. Each request yields one response on rsp (valid/stall)
// with a status bit and all four segment rows after the command.
// The cfg channel (valid/ready, always ready) writes the protected bit mask
// of row 0; write it only while no request is in flight.
// A character write or a clear goes from dispatch straight to the final
// state. A number takes, per decimal digit (up to NUM_POSITIONS digits), a
// multiply-by-reciprocal step and a remainder-and-write step; a two-digit
// write extracts both digits this way and then writes the tens digit and the
// units digit (the units write is skipped when the tens digit is rejected).
// One request is in work at a time; the next request is taken as soon as the
// previous result sits in the response register, even if it is stalled.
// If the receiver stalls, the response register holds its value and the
// controller waits in its final state before posting the next one.
// Reset clears all segment rows, the mask and the response valid.
module segment_lcd_text_writer_unit #(
  parameter int NUM_POSITIONS = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  seglcd_pkg::seglcd_req_t req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output seglcd_pkg::seglcd_rsp_t rsp,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_data
);
  import seglcd_pkg::*;

  seglcd_cmd_t cmd;
  seglcd_sts_t sts;
  logic [7:0]  protected_bits_mask;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protected_bits_mask <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      protected_bits_mask <= cfg_data;
    end
  end

  seglcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  seglcd_datapath #(
    .NUM_POSITIONS (NUM_POSITIONS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .req                 (req),
    .cmd                 (cmd),
    .protected_bits_mask (protected_bits_mask),
    .rsp_stall           (rsp_stall),
    .sts                 (sts),
    .rsp_valid           (rsp_valid),
    .rsp                 (rsp)
  );

endmodule
